// ===== rtl/core/gcd_pkg.sv =====
// ----------------------------------------------------------------------------
// gcd_pkg: shared types, denomination tables and helpers
// Currency and status codes, the control group that travels with each stage,
// and the per-slot denomination tables used by the greedy change pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package gcd_pkg;

    typedef enum logic [1:0] {
        CUR_WON = 2'd0,
        CUR_USD = 2'd1,
        CUR_YEN = 2'd2
    } t_currency;

    typedef enum logic [1:0] {
        ST_CHANGE = 2'd0,
        ST_EXACT  = 2'd1,
        ST_SHORT  = 2'd2
    } t_status;

    localparam int NUM_SLOTS   = 11;
    localparam int SMALL_SLOTS = NUM_SLOTS - 1;
    localparam int SLOT_W      = 4;
    localparam int DENOM_W     = 16;
    localparam int COUNT_W     = 12;
    localparam int SMALL_W     = 4;
    localparam int MAX_SMALL   = 9;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 12'hFFF;

    // Slot 0 is the largest note, the rest follow in descending order.
    localparam logic [DENOM_W-1:0] WON_DENOMS [NUM_SLOTS] = '{
        16'd50000, 16'd10000, 16'd5000, 16'd1000, 16'd100, 16'd50, 16'd10,
        16'd0, 16'd0, 16'd0, 16'd0
    };
    localparam logic [DENOM_W-1:0] USD_DENOMS [NUM_SLOTS] = '{
        16'd10000, 16'd5000, 16'd2000, 16'd1000, 16'd500, 16'd100, 16'd50,
        16'd25, 16'd10, 16'd5, 16'd1
    };
    localparam logic [DENOM_W-1:0] YEN_DENOMS [NUM_SLOTS] = '{
        16'd10000, 16'd5000, 16'd1000, 16'd500, 16'd100, 16'd50, 16'd10,
        16'd5, 16'd1, 16'd0, 16'd0
    };

    localparam logic [SLOT_W-1:0] WON_FIRST_COIN = 4'd4;
    localparam logic [SLOT_W-1:0] USD_FIRST_COIN = 4'd6;
    localparam logic [SLOT_W-1:0] YEN_FIRST_COIN = 4'd3;

    typedef struct packed {
        logic      valid;
        t_status   status;
        t_currency cur;
    } t_ctl;

    typedef struct packed {
        t_ctl                               ctl;
        logic [COUNT_W-1:0]                 top_cnt;
        logic [SMALL_SLOTS-1:0][SMALL_W-1:0] cnt;
    } t_item;

    typedef struct packed {
        logic [SMALL_W-1:0] cnt;
        logic [DENOM_W-1:0] rem;
    } t_step;

    function automatic logic [DENOM_W-1:0] denom_value(input t_currency cur,
                                                        input logic [SLOT_W-1:0] slot);
        logic [DENOM_W-1:0] val;
        val = '0;
        if (slot < SLOT_W'(NUM_SLOTS)) begin
            unique case (cur)
                CUR_USD: val = USD_DENOMS[slot];
                CUR_YEN: val = YEN_DENOMS[slot];
                default: val = WON_DENOMS[slot];
            endcase
        end
        return val;
    endfunction

    function automatic logic is_coin_slot(input t_currency cur,
                                          input logic [SLOT_W-1:0] slot);
        logic coin;
        unique case (cur)
            CUR_USD: coin = (slot >= USD_FIRST_COIN);
            CUR_YEN: coin = (slot >= YEN_FIRST_COIN);
            default: coin = (slot >= WON_FIRST_COIN);
        endcase
        return coin;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gcd_top_div.sv =====
// ----------------------------------------------------------------------------
// gcd_top_div: count of the largest note
// Three stages divide the change by the largest note value through a
// reciprocal multiply, then fix the quotient up by one compare and subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_top_div #(
    parameter int AMOUNT_BITS = 24
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_adv,
    input  wire gcd_pkg::t_ctl             i_ctl,
    input  wire logic [AMOUNT_BITS-1:0]    i_change,
    output gcd_pkg::t_ctl                  o_ctl,
    output logic [gcd_pkg::COUNT_W-1:0]    o_top_cnt,
    output logic [gcd_pkg::DENOM_W-1:0]    o_rem
);
    import gcd_pkg::*;

    // The quotient by 10000 or more stays below 2^(AMOUNT_BITS-13).
    localparam int MW  = AMOUNT_BITS - 13;
    localparam int QW  = MW + 1;
    localparam int QXW = (QW > COUNT_W) ? QW : COUNT_W;
    localparam int RW  = 17;
    localparam longint unsigned RECIP_HI = (64'd1 << AMOUNT_BITS) / 64'd50000;
    localparam longint unsigned RECIP_LO = (64'd1 << AMOUNT_BITS) / 64'd10000;

    t_ctl                       r_s2_ctl, r_s3_ctl, r_s4_ctl;
    logic [AMOUNT_BITS+MW-1:0]  r_s2_prod;
    logic [AMOUNT_BITS-1:0]     r_s2_change;
    logic [MW-1:0]              r_s3_q;
    logic [RW-1:0]              r_s3_r;
    logic [COUNT_W-1:0]         r_s4_cnt;
    logic [DENOM_W-1:0]         r_s4_rem;

    logic [MW-1:0]              w_recip;
    logic [MW-1:0]              w_q0;
    logic [AMOUNT_BITS:0]       w_diff;
    logic [RW-1:0]              w_d3;
    logic [QW-1:0]              w_q;
    logic [RW-1:0]              w_r;
    logic [QXW-1:0]             w_qx;
    logic [COUNT_W-1:0]         n_s4_cnt;

    assign w_recip = (i_ctl.cur == CUR_USD || i_ctl.cur == CUR_YEN) ? MW'(RECIP_LO)
                                                                     : MW'(RECIP_HI);

    assign w_q0   = r_s2_prod[AMOUNT_BITS+MW-1:AMOUNT_BITS];
    assign w_diff = {1'b0, r_s2_change}
                  - (AMOUNT_BITS+1)'(w_q0) * (AMOUNT_BITS+1)'(denom_value(r_s2_ctl.cur, '0));

    always_comb begin
        w_d3 = RW'(denom_value(r_s3_ctl.cur, '0));
        if (r_s3_r >= w_d3) begin
            w_q = QW'(r_s3_q) + QW'(1);
            w_r = r_s3_r - w_d3;
        end else begin
            w_q = QW'(r_s3_q);
            w_r = r_s3_r;
        end
        w_qx     = QXW'(w_q);
        n_s4_cnt = (w_qx > QXW'(COUNT_MAX)) ? COUNT_MAX : w_qx[COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl.valid <= 1'b0;
            r_s3_ctl.valid <= 1'b0;
            r_s4_ctl.valid <= 1'b0;
        end else if (i_adv) begin
            r_s2_ctl <= i_ctl;
            r_s3_ctl <= r_s2_ctl;
            r_s4_ctl <= r_s3_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s2_prod   <= (AMOUNT_BITS+MW)'(i_change) * (AMOUNT_BITS+MW)'(w_recip);
            r_s2_change <= i_change;
            r_s3_q      <= w_q0;
            r_s3_r      <= w_diff[RW-1:0];
            r_s4_cnt    <= n_s4_cnt;
            r_s4_rem    <= w_r[DENOM_W-1:0];
        end
    end

    assign o_ctl     = r_s4_ctl;
    assign o_top_cnt = r_s4_cnt;
    assign o_rem     = r_s4_rem;

endmodule

`default_nettype wire

// ===== rtl/core/gcd_emit.sv =====
// ----------------------------------------------------------------------------
// gcd_emit: result sequencer and output register
// Holds one item's counts and sends one result per nonzero count, or a
// single status result, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_emit (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire gcd_pkg::t_item            i_item,
    output logic                           o_adv,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [gcd_pkg::DENOM_W-1:0]    o_denom,
    output logic [gcd_pkg::COUNT_W-1:0]    o_count,
    output logic                           o_is_coin,
    output gcd_pkg::t_status               o_status,
    output logic                           o_last
);
    import gcd_pkg::*;

    logic                           r_em_valid;
    t_status                        r_em_status;
    t_currency                      r_em_cur;
    logic [NUM_SLOTS-1:0]           r_em_mask;
    logic [NUM_SLOTS-1:0][COUNT_W-1:0] r_em_cnt;

    logic                           r_out_valid;
    logic [DENOM_W-1:0]             r_out_denom;
    logic [COUNT_W-1:0]             r_out_count;
    logic                           r_out_coin;
    t_status                        r_out_status;
    logic                           r_out_last;

    logic                           w_out_free;
    logic                           w_emit;
    logic                           w_last;
    logic [NUM_SLOTS-1:0]           w_onehot;
    logic [NUM_SLOTS-1:0]           w_rest;
    logic [SLOT_W-1:0]              w_sel;
    logic [NUM_SLOTS-1:0]           n_mask;
    logic [NUM_SLOTS-1:0][COUNT_W-1:0] n_cnt;

    always_comb begin
        n_cnt[0] = i_item.top_cnt;
        for (int i = 0; i < SMALL_SLOTS; i++) begin
            n_cnt[i+1] = COUNT_W'(i_item.cnt[i]);
        end
        for (int i = 0; i < NUM_SLOTS; i++) begin
            n_mask[i] = (i_item.ctl.status == ST_CHANGE) && (n_cnt[i] != '0);
        end
    end

    always_comb begin
        w_onehot = r_em_mask & (~r_em_mask + NUM_SLOTS'(1));
        w_rest   = r_em_mask & ~w_onehot;
        w_sel    = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (w_onehot[i]) begin
                w_sel = SLOT_W'(i);
            end
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_emit     = r_em_valid && w_out_free;
    assign w_last     = (r_em_mask == '0) || (w_rest == '0);
    assign o_adv      = !r_em_valid || (w_emit && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_adv) begin
                r_em_valid <= i_item.ctl.valid;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_em_status <= i_item.ctl.status;
            r_em_cur    <= i_item.ctl.cur;
            r_em_mask   <= n_mask;
            r_em_cnt    <= n_cnt;
        end else if (w_emit) begin
            r_em_mask   <= w_rest;
        end
        if (w_emit) begin
            r_out_last <= w_last;
            if (r_em_mask == '0) begin
                r_out_denom  <= '0;
                r_out_count  <= '0;
                r_out_coin   <= 1'b0;
                r_out_status <= r_em_status;
            end else begin
                r_out_denom  <= denom_value(r_em_cur, w_sel);
                r_out_count  <= r_em_cnt[w_sel];
                r_out_coin   <= is_coin_slot(r_em_cur, w_sel);
                r_out_status <= ST_CHANGE;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_denom     = r_out_denom;
    assign o_count     = r_out_count;
    assign o_is_coin   = r_out_coin;
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;

    a_status_has_no_pieces: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_em_valid && r_em_status != ST_CHANGE |-> r_em_mask == '0)
        else $error("status item holds pending pieces");

    a_status_result_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status != ST_CHANGE |-> r_out_last && r_out_count == '0)
        else $error("status result is not a lone final result");

    a_pieces_have_denom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_count != '0 |-> r_out_denom != '0)
        else $error("pieces reported without a denomination");

    a_mask_drains_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit && !w_last |=> r_em_valid
            && $countones(r_em_mask) == $countones($past(r_em_mask)) - 1)
        else $error("pending slot mask did not drop exactly one slot");

endmodule

`default_nettype wire

// ===== rtl/core/greedy_change_dispense.sv =====
// ----------------------------------------------------------------------------
// greedy_change_dispense: greedy breakdown of change into notes and coins
// The first result of a transaction passes the subtract stage, the largest-note
// divider, the greedy-step stages, the sequencer and the output register. The
// sequencer sends the results of an input, one to eleven of them, in turn and
// takes the next input only as it sends the last one, so the single-result
// output port limits how fast inputs are accepted.
// Reset clears every stage and output valid bit and sets the currency to won.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_change_dispense #(
    parameter int AMOUNT_BITS = 24,
    localparam int IN_W = ((2 * AMOUNT_BITS + 7) / 8) * 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,

    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_wdata,   // currency code

    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // charge_amount, payment_amount, zero padding
    input  wire logic [IN_W-1:0]   s_axis_tdata,

    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // denomination [15:0], piece_count [27:16], zero padding [31:28]
    output logic [31:0]            m_axis_tdata,
    // is_coin [0], status [2:1]
    output logic [2:0]             m_axis_tuser,
    output logic                   m_axis_tlast
);
    import gcd_pkg::*;

    // The currency register. Code 3 is treated as won, so it is folded into
    // won when written and only three codes ever reach the pipeline.
    t_currency r_currency;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_currency <= CUR_WON;
        end else if (i_cfg_we) begin
            if (t_currency'(i_cfg_wdata) == CUR_USD) begin
                r_currency <= CUR_USD;
            end else if (t_currency'(i_cfg_wdata) == CUR_YEN) begin
                r_currency <= CUR_YEN;
            end else begin
                r_currency <= CUR_WON;
            end
        end
    end

    // One advance signal moves every stage at once. The sequencer at the end
    // drops it only while it still has results of an earlier transaction to
    // send, so a stall holds every stage in place and nothing is lost.
    logic w_adv;

    assign s_axis_tready = w_adv;

    // Stage 1: subtract and classify. The borrow bit of the subtraction flags
    // a short payment; equal amounts give the exact-payment status.
    logic [AMOUNT_BITS-1:0] w_charge, w_pay;
    logic [AMOUNT_BITS:0]   w_diff;
    t_ctl                   n_s1_ctl;
    t_ctl                   r_s1_ctl;
    logic [AMOUNT_BITS-1:0] r_s1_change;

    assign w_charge = s_axis_tdata[AMOUNT_BITS-1:0];
    assign w_pay    = s_axis_tdata[2*AMOUNT_BITS-1:AMOUNT_BITS];
    assign w_diff   = {1'b0, w_pay} - {1'b0, w_charge};

    always_comb begin
        n_s1_ctl.valid = s_axis_tvalid;
        n_s1_ctl.cur   = r_currency;
        if (w_pay == w_charge) begin
            n_s1_ctl.status = ST_EXACT;
        end else if (w_diff[AMOUNT_BITS]) begin
            n_s1_ctl.status = ST_SHORT;
        end else begin
            n_s1_ctl.status = ST_CHANGE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl.valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_ctl <= n_s1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_change <= w_diff[AMOUNT_BITS-1:0];
        end
    end

    // Stages 2 to 4: count of the largest note and the remainder below it.
    // Every note is a multiple of the smallest note, so one greedy pass over
    // notes and coins together gives the same counts as splitting the change
    // into a note part and a coin part first.
    t_ctl               w_s4_ctl;
    logic [COUNT_W-1:0] w_s4_top;
    logic [DENOM_W-1:0] w_s4_rem;

    gcd_top_div #(
        .AMOUNT_BITS (AMOUNT_BITS)
    ) u_top_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_ctl     (r_s1_ctl),
        .i_change  (r_s1_change),
        .o_ctl     (w_s4_ctl),
        .o_top_cnt (w_s4_top),
        .o_rem     (w_s4_rem)
    );

    // One greedy step on a remainder below the previous denomination. Each
    // later count is at most nine, so all nine multiples are compared at once.
    function automatic t_step slot_step(input logic [DENOM_W-1:0] rem,
                                        input logic [DENOM_W-1:0] denom);
        t_step       res;
        logic [19:0] mult;
        res.cnt = '0;
        res.rem = rem;
        if (denom != '0) begin
            for (int k = 1; k <= MAX_SMALL; k++) begin
                mult = 20'(denom) * 20'(k);
                if (20'(rem) >= mult) begin
                    res.cnt = SMALL_W'(k);
                    res.rem = rem - mult[DENOM_W-1:0];
                end
            end
        end
        return res;
    endfunction

    // Stage 5 handles slots one to four, stage 6 slots five to eight, and
    // slots nine and ten are worked out on the way into the sequencer.
    localparam int S5_SLOTS = 4;
    localparam int S6_SLOTS = 8;

    t_ctl                                r_s5_ctl, r_s6_ctl;
    logic [COUNT_W-1:0]                  r_s5_top, r_s6_top;
    logic [DENOM_W-1:0]                  r_s5_rem, r_s6_rem;
    logic [S5_SLOTS-1:0][SMALL_W-1:0]    r_s5_cnt, n_s5_cnt;
    logic [S6_SLOTS-1:0][SMALL_W-1:0]    r_s6_cnt, n_s6_cnt;
    logic [DENOM_W-1:0]                  n_s5_rem, n_s6_rem;
    t_item                               w_item;

    always_comb begin
        t_step              v_st;
        logic [DENOM_W-1:0] v_rem;
        v_rem = w_s4_rem;
        for (int j = 0; j < S5_SLOTS; j++) begin
            v_st        = slot_step(v_rem, denom_value(w_s4_ctl.cur, SLOT_W'(j + 1)));
            n_s5_cnt[j] = v_st.cnt;
            v_rem       = v_st.rem;
        end
        n_s5_rem = v_rem;
    end

    always_comb begin
        t_step              v_st;
        logic [DENOM_W-1:0] v_rem;
        v_rem = r_s5_rem;
        n_s6_cnt[S5_SLOTS-1:0] = r_s5_cnt;
        for (int j = S5_SLOTS; j < S6_SLOTS; j++) begin
            v_st        = slot_step(v_rem, denom_value(r_s5_ctl.cur, SLOT_W'(j + 1)));
            n_s6_cnt[j] = v_st.cnt;
            v_rem       = v_st.rem;
        end
        n_s6_rem = v_rem;
    end

    always_comb begin
        t_step              v_st;
        logic [DENOM_W-1:0] v_rem;
        v_rem = r_s6_rem;
        w_item.ctl                  = r_s6_ctl;
        w_item.top_cnt              = r_s6_top;
        w_item.cnt[S6_SLOTS-1:0]    = r_s6_cnt;
        for (int j = S6_SLOTS; j < SMALL_SLOTS; j++) begin
            v_st          = slot_step(v_rem, denom_value(r_s6_ctl.cur, SLOT_W'(j + 1)));
            w_item.cnt[j] = v_st.cnt;
            v_rem         = v_st.rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_ctl.valid <= 1'b0;
            r_s6_ctl.valid <= 1'b0;
        end else if (w_adv) begin
            r_s5_ctl <= w_s4_ctl;
            r_s6_ctl <= r_s5_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s5_top <= w_s4_top;
            r_s5_rem <= n_s5_rem;
            r_s5_cnt <= n_s5_cnt;
            r_s6_top <= r_s5_top;
            r_s6_rem <= n_s6_rem;
            r_s6_cnt <= n_s6_cnt;
        end
    end

    // Stage 7 and the output register: the sequencer walks the nonzero
    // counts from the largest denomination down, one result per cycle unless the
    // master side stalls, and takes the next transaction in the cycle that it sends its last result.
    logic [DENOM_W-1:0] w_denom;
    logic [COUNT_W-1:0] w_count;
    logic               w_is_coin;
    t_status            w_status;

    gcd_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_item),
        .o_adv       (w_adv),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_denom     (w_denom),
        .o_count     (w_count),
        .o_is_coin   (w_is_coin),
        .o_status    (w_status),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, w_count, w_denom};
    assign m_axis_tuser = {w_status, w_is_coin};

endmodule

`default_nettype wire
